[hdl/sha1_pkg.sv]
package sha1_pkg;

   localparam int unsigned WORD_BITS    = 32;
   localparam int unsigned BLOCK_WORDS  = 16;
   localparam int unsigned BLOCK_BYTES  = 64;
   localparam int unsigned LEN_START    = 56;
   localparam int unsigned ROUNDS       = 80;
   localparam int unsigned ROUND_GROUP  = 20;
   localparam int unsigned DIGEST_WORDS = 5;
   localparam int unsigned ROUND_BITS   = 7;
   localparam int unsigned COUNT_BITS   = 6;
   localparam int unsigned INDEX_BITS   = 3;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [7:0]           byte_type;

   localparam word_type K_0 = 32'h5A827999;
   localparam word_type K_1 = 32'h6ED9EBA1;
   localparam word_type K_2 = 32'h8F1BBCDC;
   localparam word_type K_3 = 32'hCA62C1D6;

   localparam word_type IV_VALUES [DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam byte_type PAD_MARK = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_ZERO,
      ST_LENGTH,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic     shift_byte;
      byte_type value;
      logic     schedule;
   } buf_ctrl_type;

   typedef struct packed {
      logic start;
      logic step;
   } round_ctrl_type;

   typedef struct packed {
      logic update;
      logic emit;
   } seq_out_type;

   typedef struct packed {
      word_type w0;
      word_type w2;
      word_type w8;
      word_type w13;
   } sched_taps_type;

endpackage

[hdl/sha1_if.sv]
interface sha1_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  word_index;
   logic [31:0] digest_word;
   logic        last_word;

   modport source (output valid, word_index, digest_word, last_word, input ready);
   modport sink   (input valid, word_index, digest_word, last_word, output ready);
endinterface

[hdl/sha1_msg_buffer.sv]
module sha1_msg_buffer (
   input  logic                    clock,
   input  sha1_pkg::buf_ctrl_type  ctrl,
   input  sha1_pkg::word_type      sched_word,
   output sha1_pkg::sched_taps_type taps
);
   import sha1_pkg::*;

   word_type words_ff [BLOCK_WORDS];

   // bytes enter at the low end so the first byte of a block ends up in word 0, high byte
   always_ff @(posedge clock) begin
      if (ctrl.shift_byte) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            words_ff[i] <= {words_ff[i][WORD_BITS-9:0], words_ff[i+1][WORD_BITS-1:WORD_BITS-8]};
         end
         words_ff[BLOCK_WORDS-1] <= {words_ff[BLOCK_WORDS-1][WORD_BITS-9:0], ctrl.value};
      end else if (ctrl.schedule) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            words_ff[i] <= words_ff[i+1];
         end
         words_ff[BLOCK_WORDS-1] <= sched_word;
      end
   end

   assign taps.w0  = words_ff[0];
   assign taps.w2  = words_ff[2];
   assign taps.w8  = words_ff[8];
   assign taps.w13 = words_ff[13];

endmodule

[hdl/sha1_round_unit.sv]
module sha1_round_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  sha1_pkg::round_ctrl_type ctrl,
   input  sha1_pkg::word_type       chain [sha1_pkg::DIGEST_WORDS],
   input  sha1_pkg::sched_taps_type taps,
   output sha1_pkg::word_type       sched_word,
   output sha1_pkg::word_type       work [sha1_pkg::DIGEST_WORDS],
   output logic                     done
);
   import sha1_pkg::*;

   logic [ROUND_BITS-1:0] round_ff, round_in;
   word_type              work_ff [DIGEST_WORDS];
   word_type              mix;
   word_type              f;
   word_type              k;
   word_type              t;
   word_type              a, b, c, d, e;

   assign a = work_ff[0];
   assign b = work_ff[1];
   assign c = work_ff[2];
   assign d = work_ff[3];
   assign e = work_ff[4];

   always_comb begin
      mix = taps.w13 ^ taps.w8 ^ taps.w2 ^ taps.w0;
      // first sixteen rounds recirculate the block words unchanged
      if (round_ff < ROUND_BITS'(BLOCK_WORDS)) begin
         sched_word = taps.w0;
      end else begin
         sched_word = {mix[WORD_BITS-2:0], mix[WORD_BITS-1]};
      end
      if (round_ff < ROUND_BITS'(ROUND_GROUP)) begin
         f = (b & c) | (~b & d);
         k = K_0;
      end else if (round_ff < ROUND_BITS'(2 * ROUND_GROUP)) begin
         f = b ^ c ^ d;
         k = K_1;
      end else if (round_ff < ROUND_BITS'(3 * ROUND_GROUP)) begin
         f = (b & c) | (b & d) | (c & d);
         k = K_2;
      end else begin
         f = b ^ c ^ d;
         k = K_3;
      end
      t = {a[WORD_BITS-6:0], a[WORD_BITS-1:WORD_BITS-5]} + f + e + k + sched_word;
      round_in = round_ff;
      if (ctrl.start) begin
         round_in = '0;
      end else if (ctrl.step) begin
         round_in = round_ff + ROUND_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
      end else begin
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            work_ff[i] <= chain[i];
         end
      end else if (ctrl.step) begin
         work_ff[0] <= t;
         work_ff[1] <= a;
         work_ff[2] <= {b[1:0], b[WORD_BITS-1:2]};
         work_ff[3] <= c;
         work_ff[4] <= d;
      end
   end

   assign work = work_ff;
   assign done = (round_ff == ROUND_BITS'(ROUNDS - 1));

endmodule

[hdl/sha1_ctrl.sv]
module sha1_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               data_byte,
   input  logic                     has_byte,
   input  logic                     end_of_message,
   input  logic                     round_done,
   input  logic                     emit_last,
   output logic                     ready,
   output sha1_pkg::buf_ctrl_type   buf_ctrl,
   output sha1_pkg::round_ctrl_type round_ctrl,
   output sha1_pkg::seq_out_type    seq
);
   import sha1_pkg::*;

   state_type             state_ff, state_in;
   state_type             ret_ff, ret_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [63:0]           len_ff, len_in;
   logic [COUNT_BITS-1:0] next_count;
   logic                  count_wrap;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         count_ff <= '0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         count_ff <= count_in;
         len_ff   <= len_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      count_in   = count_ff;
      len_in     = len_ff;
      ready      = 1'b0;
      buf_ctrl   = '0;
      round_ctrl = '0;
      seq        = '0;
      next_count = count_ff + COUNT_BITS'(1);
      count_wrap = (count_ff == COUNT_BITS'(BLOCK_BYTES - 1));

      unique case (state_ff) inside
         ST_IDLE: begin
            ready = 1'b1;
            if (accept) begin
               if (has_byte) begin
                  buf_ctrl.shift_byte = 1'b1;
                  buf_ctrl.value      = data_byte;
                  count_in            = next_count;
                  len_in              = {len_ff[63:3] + 61'd1, 3'b000};
               end
               // a byte that fills the block is compressed before any padding
               if (has_byte && count_wrap) begin
                  state_in = ST_ROUND;
                  ret_in   = end_of_message ? ST_MARK : ST_IDLE;
               end else if (end_of_message) begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_MARK, ST_ZERO: begin
            buf_ctrl.shift_byte = 1'b1;
            buf_ctrl.value      = (state_ff == ST_MARK) ? PAD_MARK : 8'h00;
            count_in            = next_count;
            if (count_wrap) begin
               // no room for the length, it goes in an extra block
               state_in = ST_ROUND;
               ret_in   = ST_ZERO;
            end else if (next_count == COUNT_BITS'(LEN_START)) begin
               state_in = ST_LENGTH;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_LENGTH: begin
            buf_ctrl.shift_byte = 1'b1;
            buf_ctrl.value      = len_ff[63:56];
            len_in              = {len_ff[55:0], 8'h00};
            count_in            = next_count;
            if (count_wrap) begin
               state_in = ST_ROUND;
               ret_in   = ST_EMIT;
            end
         end
         ST_ROUND: begin
            round_ctrl.step   = 1'b1;
            buf_ctrl.schedule = 1'b1;
            if (round_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            seq.update = 1'b1;
            state_in   = ret_ff;
         end
         ST_EMIT: begin
            seq.emit = 1'b1;
            if (emit_last) begin
               state_in = ST_IDLE;
               count_in = '0;
               len_in   = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      round_ctrl.start = (state_in == ST_ROUND) && (state_ff != ST_ROUND);
   end

endmodule

[hdl/sha1_message_digest_unit.sv]
// channel   dir  handshake      payload
// req_port  in   valid/ready    data_byte[7:0], has_byte, end_of_message
// rsp_port  out  valid/ready    word_index[2:0], digest_word[31:0], last_word
//
// a plain byte item is shifted into the buffer; the byte that fills a 64-byte block
// also starts a compression (80 rounds on the one round adder, then the chaining add).
// an end item pads one byte per cycle up to the next block end, with one or two
// compressions, then the five digest words, one per handshake.
// reset (synchronous, active high) restores the initial chaining value.
// req_port.ready is low after a block-filling or end item until the chaining add
// or the last digest word is done.
module sha1_message_digest_unit (
   input  logic        clock,
   input  logic        reset,
   sha1_req_if.sink    req_port,
   sha1_rsp_if.source  rsp_port
);
   import sha1_pkg::*;

   buf_ctrl_type          buf_ctrl;
   round_ctrl_type        round_ctrl;
   seq_out_type           seq;
   sched_taps_type        taps;
   word_type              sched_word;
   word_type              work [DIGEST_WORDS];
   word_type              chain_ff [DIGEST_WORDS];
   logic [INDEX_BITS-1:0] word_idx_ff, word_idx_in;
   logic                  round_done;
   logic                  ready;
   logic                  out_take;
   logic                  emit_last;

   assign req_port.ready = ready;
   assign out_take  = rsp_port.valid && rsp_port.ready;
   assign emit_last = out_take && (word_idx_ff == INDEX_BITS'(DIGEST_WORDS - 1));

   sha1_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_port.valid && ready),
      .data_byte      (req_port.data_byte),
      .has_byte       (req_port.has_byte),
      .end_of_message (req_port.end_of_message),
      .round_done     (round_done),
      .emit_last      (emit_last),
      .ready          (ready),
      .buf_ctrl       (buf_ctrl),
      .round_ctrl     (round_ctrl),
      .seq            (seq)
   );

   sha1_msg_buffer u_buffer (
      .clock      (clock),
      .ctrl       (buf_ctrl),
      .sched_word (sched_word),
      .taps       (taps)
   );

   sha1_round_unit u_round (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (round_ctrl),
      .chain      (chain_ff),
      .taps       (taps),
      .sched_word (sched_word),
      .work       (work),
      .done       (round_done)
   );

   always_comb begin
      word_idx_in = word_idx_ff;
      if (emit_last) begin
         word_idx_in = '0;
      end else if (out_take) begin
         word_idx_in = word_idx_ff + INDEX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_idx_ff <= '0;
      end else begin
         word_idx_ff <= word_idx_in;
      end
   end

   // chaining value goes back to the initial words once the digest is out
   always_ff @(posedge clock) begin
      if (reset || emit_last) begin
         chain_ff <= IV_VALUES;
      end else if (seq.update) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_ff[i] <= chain_ff[i] + work[i];
         end
      end
   end

   assign rsp_port.valid       = seq.emit;
   assign rsp_port.word_index  = word_idx_ff;
   assign rsp_port.digest_word = chain_ff[word_idx_ff];
   assign rsp_port.last_word   = (word_idx_ff == INDEX_BITS'(DIGEST_WORDS - 1));

endmodule

[hdl/sha1_checker.sv]
module sha1_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  word_index,
   input logic [31:0] digest_word,
   input logic        last_word
);

   // a waiting word is neither dropped nor changed
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(word_index) && $stable(digest_word))
      else $error("digest word dropped or changed while stalled");

   // no new item is taken while the digest is going out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("input ready while digest words pending");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last_word == (word_index == 3'd4)))
      else $error("last_word does not match word_index");

   // the five words follow one another with no gap in numbering
   a_word_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_word |=>
         rsp_valid && (word_index == $past(word_index) + 3'd1))
      else $error("digest words out of sequence");

   a_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && last_word |=> !rsp_valid && !$past(req_valid && req_ready))
      else $error("extra digest word after the last");

endmodule

bind sha1_message_digest_unit sha1_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_port.valid),
   .req_ready   (req_port.ready),
   .rsp_valid   (rsp_port.valid),
   .rsp_ready   (rsp_port.ready),
   .word_index  (rsp_port.word_index),
   .digest_word (rsp_port.digest_word),
   .last_word   (rsp_port.last_word)
);
